[hdl/rwt_pkg.sv]
// ============================================================================
// rwt_pkg - retransmit window tracker shared definitions
// Request and result codes, controller commands and datapath status.
// ============================================================================
package rwt_pkg;

    localparam logic [15:0] RETRY_RESET = 16'd500;
    localparam int          MAX_RES     = 8;
    localparam int          CNT_W       = 4;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_SEND = 2'd1,
        REQ_TICK = 2'd2,
        REQ_ACK  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        KIND_ADD_OK      = 3'd0,
        KIND_ADD_REFUSED = 3'd1,
        KIND_SEND_ARMED  = 3'd2,
        KIND_RESEND      = 3'd3,
        KIND_ACK         = 3'd4,
        KIND_TICK_IDLE   = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ADD,
        OP_SEND,
        OP_TICK_IDLE,
        OP_TICK_START,
        OP_TICK_STEP,
        OP_TICK_DONE,
        OP_ACK_START,
        OP_ACK_STEP,
        OP_ACK_DONE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic latch;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic ack_stop;
        logic busy_flag;
    } stat_t;

endpackage

[hdl/rwt_ctrl.sv]
// ============================================================================
// rwt_ctrl - retransmit window tracker controller
// Sequences one request at a time and steps the datapath through slot scans.
// ============================================================================
module rwt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     req_type,
    input  rwt_pkg::stat_t stat,
    output rwt_pkg::cmd_t  cmd,
    output logic           busy
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_TICK      = 5'b00010,
        S_TICK_DONE = 5'b00100,
        S_ACK       = 5'b01000,
        S_ACK_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = rwt_pkg::OP_NONE;
        cmd.latch  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    unique case (rwt_pkg::req_t'(req_type))
                        rwt_pkg::REQ_ADD:  cmd.op = rwt_pkg::OP_ADD;
                        rwt_pkg::REQ_SEND: cmd.op = rwt_pkg::OP_SEND;
                        rwt_pkg::REQ_TICK:
                        begin
                            if (stat.busy_flag)
                            begin
                                cmd.op     = rwt_pkg::OP_TICK_START;
                                state_next = S_TICK;
                            end
                            else
                            begin
                                cmd.op = rwt_pkg::OP_TICK_IDLE;
                            end
                        end
                        rwt_pkg::REQ_ACK:
                        begin
                            cmd.op     = rwt_pkg::OP_ACK_START;
                            state_next = S_ACK;
                        end
                        default: cmd.op = rwt_pkg::OP_NONE;
                    endcase
                end
            end
            S_TICK:
            begin
                cmd.op = rwt_pkg::OP_TICK_STEP;
                if (stat.at_end)
                begin
                    state_next = S_TICK_DONE;
                end
            end
            S_TICK_DONE:
            begin
                cmd.op     = rwt_pkg::OP_TICK_DONE;
                state_next = S_IDLE;
            end
            S_ACK:
            begin
                cmd.op = rwt_pkg::OP_ACK_STEP;
                if (stat.ack_stop || stat.at_end)
                begin
                    state_next = S_ACK_DONE;
                end
            end
            S_ACK_DONE:
            begin
                cmd.op     = rwt_pkg::OP_ACK_DONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/rwt_datapath.sv]
// ============================================================================
// rwt_datapath - retransmit window tracker datapath
// Slot storage, timer update, match compare, retry register and result regs.
// ============================================================================
module rwt_datapath #(
    parameter int WINDOW = 8,
    parameter int IW     = 3
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  rwt_pkg::cmd_t  cmd,
    output rwt_pkg::stat_t stat,
    input  logic           cfg_write,
    input  logic [15:0]    cfg_data,
    input  logic [7:0]     packet_handle,
    input  logic [15:0]    packet_number,
    input  logic [31:0]    packet_checksum,
    input  logic           ack_delivered,
    input  logic [15:0]    elapsed,
    output logic           result_valid,
    output logic [2:0]     result_kind,
    output logic [2:0]     slot,
    output logic [7:0]     out_handle,
    output logic [15:0]    out_number,
    output logic           slot_freed,
    output logic           busy_res,
    output logic           last
);

    logic [7:0]  handle_mem   [WINDOW];
    logic [15:0] number_mem   [WINDOW];
    logic [31:0] checksum_mem [WINDOW];
    logic [31:0] timer_mem    [WINDOW];

    logic [15:0]               retry_reg;
    logic [WINDOW-1:0]         used_reg,      used_next;
    logic                      busy_flag_reg, busy_flag_next;
    logic [IW-1:0]             idx_reg,       idx_next;
    logic [rwt_pkg::CNT_W-1:0] cnt_reg,       cnt_next;
    logic                      pend_vld_reg,  pend_vld_next;
    logic [2:0]                pend_slot_reg, pend_slot_next;
    logic [7:0]                pend_hdl_reg,  pend_hdl_next;
    logic [15:0]               pend_num_reg,  pend_num_next;
    logic                      freed_reg,     freed_next;
    logic [2:0]                fslot_reg,     fslot_next;
    logic [15:0]               num_reg,       num_next;
    logic [31:0]               chk_reg,       chk_next;
    logic                      dlv_reg,       dlv_next;
    logic [15:0]               elap_reg,      elap_next;
    logic                      valid_reg,     valid_next;
    logic [2:0]                kind_reg,      kind_next;
    logic [2:0]                slot_reg,      slot_next;
    logic [7:0]                ohdl_reg,      ohdl_next;
    logic [15:0]               onum_reg,      onum_next;
    logic                      ofreed_reg,    ofreed_next;
    logic                      obusy_reg,     obusy_next;
    logic                      last_reg,      last_next;

    logic [IW-1:0] free_idx;
    logic          full;
    logic          add_ok;
    logic          cur_used;
    logic [32:0]   sum;
    logic [31:0]   tsat;
    logic          expire;
    logic          match;
    logic          at_end;
    logic [IW-1:0] idx_inc;

    always_comb
    begin
        free_idx = '0;
        for (int i = WINDOW - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign full     = &used_reg;
    assign add_ok   = (cmd.op == rwt_pkg::OP_ADD) && !busy_flag_reg && !full;
    assign cur_used = used_reg[idx_reg];
    assign sum      = {1'b0, timer_mem[idx_reg]} + {17'd0, elap_reg};
    assign tsat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign expire   = (tsat >= {16'd0, retry_reg});
    assign match    = cur_used && (checksum_mem[idx_reg] == chk_reg)
                      && (number_mem[idx_reg] == num_reg);
    assign at_end   = (idx_reg == IW'(WINDOW - 1));
    assign idx_inc  = at_end ? '0 : idx_reg + IW'(1);

    assign stat.at_end    = at_end;
    assign stat.ack_stop  = match;
    assign stat.busy_flag = busy_flag_reg;

    always_ff @(posedge clk)
    begin
        if (add_ok)
        begin
            handle_mem[free_idx]   <= packet_handle;
            number_mem[free_idx]   <= packet_number;
            checksum_mem[free_idx] <= packet_checksum;
            timer_mem[free_idx]    <= {16'd0, retry_reg};
        end
        else if ((cmd.op == rwt_pkg::OP_TICK_STEP) && cur_used)
        begin
            timer_mem[idx_reg] <= expire ? 32'd0 : tsat;
        end
    end

    always_comb
    begin
        used_next      = used_reg;
        busy_flag_next = busy_flag_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        pend_hdl_next  = pend_hdl_reg;
        pend_num_next  = pend_num_reg;
        freed_next     = freed_reg;
        fslot_next     = fslot_reg;
        num_next       = num_reg;
        chk_next       = chk_reg;
        dlv_next       = dlv_reg;
        elap_next      = elap_reg;
        valid_next     = 1'b0;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        ohdl_next      = ohdl_reg;
        onum_next      = onum_reg;
        ofreed_next    = ofreed_reg;
        obusy_next     = obusy_reg;
        last_next      = last_reg;

        if (cmd.latch)
        begin
            num_next  = packet_number;
            chk_next  = packet_checksum;
            dlv_next  = ack_delivered;
            elap_next = elapsed;
        end

        unique case (cmd.op)
            rwt_pkg::OP_ADD:
            begin
                valid_next  = 1'b1;
                ohdl_next   = '0;
                onum_next   = '0;
                ofreed_next = 1'b0;
                obusy_next  = busy_flag_reg;
                last_next   = 1'b1;
                if (add_ok)
                begin
                    used_next[free_idx] = 1'b1;
                    kind_next           = rwt_pkg::KIND_ADD_OK;
                    slot_next           = 3'(free_idx);
                end
                else
                begin
                    kind_next = rwt_pkg::KIND_ADD_REFUSED;
                    slot_next = '0;
                end
            end
            rwt_pkg::OP_SEND:
            begin
                busy_flag_next = busy_flag_reg | (|used_reg);
                valid_next     = 1'b1;
                kind_next      = rwt_pkg::KIND_SEND_ARMED;
                slot_next      = '0;
                ohdl_next      = '0;
                onum_next      = '0;
                ofreed_next    = 1'b0;
                obusy_next     = busy_flag_next;
                last_next      = 1'b1;
            end
            rwt_pkg::OP_TICK_IDLE:
            begin
                valid_next  = 1'b1;
                kind_next   = rwt_pkg::KIND_TICK_IDLE;
                slot_next   = '0;
                ohdl_next   = '0;
                onum_next   = '0;
                ofreed_next = 1'b0;
                obusy_next  = busy_flag_reg;
                last_next   = 1'b1;
            end
            rwt_pkg::OP_TICK_START:
            begin
                idx_next      = '0;
                cnt_next      = '0;
                pend_vld_next = 1'b0;
            end
            rwt_pkg::OP_TICK_STEP:
            begin
                idx_next = idx_inc;
                if (cur_used && expire
                    && (cnt_reg < rwt_pkg::CNT_W'(rwt_pkg::MAX_RES)))
                begin
                    if (pend_vld_reg)
                    begin
                        valid_next  = 1'b1;
                        kind_next   = rwt_pkg::KIND_RESEND;
                        slot_next   = pend_slot_reg;
                        ohdl_next   = pend_hdl_reg;
                        onum_next   = pend_num_reg;
                        ofreed_next = 1'b0;
                        obusy_next  = busy_flag_reg;
                        last_next   = 1'b0;
                    end
                    pend_vld_next  = 1'b1;
                    pend_slot_next = 3'(idx_reg);
                    pend_hdl_next  = handle_mem[idx_reg];
                    pend_num_next  = number_mem[idx_reg];
                    cnt_next       = cnt_reg + rwt_pkg::CNT_W'(1);
                end
            end
            rwt_pkg::OP_TICK_DONE:
            begin
                valid_next  = 1'b1;
                ofreed_next = 1'b0;
                obusy_next  = busy_flag_reg;
                last_next   = 1'b1;
                if (pend_vld_reg)
                begin
                    kind_next = rwt_pkg::KIND_RESEND;
                    slot_next = pend_slot_reg;
                    ohdl_next = pend_hdl_reg;
                    onum_next = pend_num_reg;
                end
                else
                begin
                    kind_next = rwt_pkg::KIND_TICK_IDLE;
                    slot_next = '0;
                    ohdl_next = '0;
                    onum_next = '0;
                end
                pend_vld_next = 1'b0;
            end
            rwt_pkg::OP_ACK_START:
            begin
                idx_next   = '0;
                freed_next = 1'b0;
            end
            rwt_pkg::OP_ACK_STEP:
            begin
                idx_next = idx_inc;
                if (match && dlv_reg)
                begin
                    used_next[idx_reg] = 1'b0;
                    freed_next         = 1'b1;
                    fslot_next         = 3'(idx_reg);
                end
            end
            rwt_pkg::OP_ACK_DONE:
            begin
                busy_flag_next = |used_reg;
                valid_next     = 1'b1;
                kind_next      = rwt_pkg::KIND_ACK;
                slot_next      = freed_reg ? fslot_reg : 3'd0;
                ohdl_next      = '0;
                onum_next      = '0;
                ofreed_next    = freed_reg;
                obusy_next     = |used_reg;
                last_next      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_reg     <= rwt_pkg::RETRY_RESET;
            used_reg      <= '0;
            busy_flag_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            freed_reg     <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                retry_reg <= cfg_data;
            end
            used_reg      <= used_next;
            busy_flag_reg <= busy_flag_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            pend_vld_reg  <= pend_vld_next;
            freed_reg     <= freed_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_hdl_reg  <= pend_hdl_next;
        pend_num_reg  <= pend_num_next;
        fslot_reg     <= fslot_next;
        num_reg       <= num_next;
        chk_reg       <= chk_next;
        dlv_reg       <= dlv_next;
        elap_reg      <= elap_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        ohdl_reg      <= ohdl_next;
        onum_reg      <= onum_next;
        ofreed_reg    <= ofreed_next;
        obusy_reg     <= obusy_next;
        last_reg      <= last_next;
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign slot         = slot_reg;
    assign out_handle   = ohdl_reg;
    assign out_number   = onum_reg;
    assign slot_freed   = ofreed_reg;
    assign busy_res     = obusy_reg;
    assign last         = last_reg;

endmodule

[hdl/retransmit_window_tracker.sv]
// ============================================================================
// retransmit_window_tracker - sender retransmission window
// Tracks unacknowledged datagrams in WINDOW slots and reports resends.
// ============================================================================
// A request is taken when start is high and busy is low. Add, send and a tick
// on an unarmed window need no scan. An armed tick scans the whole window one
// slot per cycle; an acknowledgement scans until the first matching used slot
// or the end of the window. The slot scan is the single timer adder and
// compare unit stepping through the slots. Results appear one per cycle on
// result_valid and must be taken when shown: the receiver cannot stall them.
// last marks the final result of a request.
module retransmit_window_tracker #(
    parameter int WINDOW = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  req_type,
    input  logic [7:0]  packet_handle,
    input  logic [15:0] packet_number,
    input  logic [31:0] packet_checksum,
    input  logic        ack_delivered,
    input  logic [15:0] elapsed,
    output logic        result_valid,
    output logic [2:0]  result_kind,
    output logic [2:0]  slot,
    output logic [7:0]  out_handle,
    output logic [15:0] out_number,
    output logic        slot_freed,
    output logic        busy_res,
    output logic        last
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    rwt_pkg::cmd_t  cmd;
    rwt_pkg::stat_t stat;

    rwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    rwt_datapath #(
        .WINDOW (WINDOW),
        .IW     (IW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .packet_handle   (packet_handle),
        .packet_number   (packet_number),
        .packet_checksum (packet_checksum),
        .ack_delivered   (ack_delivered),
        .elapsed         (elapsed),
        .result_valid    (result_valid),
        .result_kind     (result_kind),
        .slot            (slot),
        .out_handle      (out_handle),
        .out_number      (out_number),
        .slot_freed      (slot_freed),
        .busy_res        (busy_res),
        .last            (last)
    );

endmodule
